// ===== design/iqe_pkg.sv =====
package iqe_pkg;

  localparam int NUM_SPINS = 64;
  localparam int IDX_W     = $clog2(NUM_SPINS);
  localparam int ADDR_W    = $clog2(NUM_SPINS * NUM_SPINS);
  localparam int ROW_W     = 6;
  localparam int COEF_W    = 16;
  localparam int RES_W     = 32;
  localparam int CMP_W     = ((IDX_W > ROW_W) ? IDX_W : ROW_W) + 1;
  localparam int ACC_W     = COEF_W + ADDR_W + 3;
  localparam int SAT_W     = (ACC_W > RES_W) ? ACC_W : RES_W + 1;

  localparam logic KIND_FLIP   = 1'b0;
  localparam logic KIND_ENERGY = 1'b1;

  typedef enum logic [1:0] {
    FUNC_COEF,
    FUNC_SPIN,
    FUNC_FLIP,
    FUNC_ENERGY
  } func_t;

  typedef enum logic [1:0] {
    TERM_NONE,
    TERM_ADD,
    TERM_SUB
  } term_t;

  typedef enum logic [2:0] {
    FIN_POS,
    FIN_NEG,
    FIN_POS2,
    FIN_NEG2,
    FIN_ZERO
  } fin_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WR_A,
    S_WR_B,
    S_FLIP,
    S_ENERGY,
    S_FIN
  } state_t;

  typedef struct packed {
    logic  term_en;
    logic  first;
    term_t term;
    logic  fin_en;
    fin_t  fin;
    logic  kind;
  } acc_ctrl_t;

  function automatic logic in_range(logic [ROW_W-1:0] v);
    return CMP_W'(v) < CMP_W'(NUM_SPINS);
  endfunction

  function automatic logic [ADDR_W-1:0] coef_addr(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(NUM_SPINS)) + ADDR_W'(c);
  endfunction

endpackage

// ===== design/ising_qubo_energy_engine_core.sv =====
// channel  | handshake            | payload
// ---------+----------------------+--------------------------------------------------
// config   | cfg_we               | cfg_wdata (model_kind)
// input    | in_valid / in_ready  | func, row_index, col_index, coef_value, spin_value
// output   | out_valid / out_ready| result_value, result_kind, saturated
//
// spin write: spin register only; coefficient write: one ram-port write per mirror entry
// flip query: one coefficient read of row i per cycle into the accumulator
// energy query: walks the upper triangle, diagonal included
// reset sets all spins to one and model_kind to ising; coefficients are undefined until written
// in_ready is low while an item is in work; a result waiting on out_ready holds only the
// final step of the next query
module ising_qubo_energy_engine_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        func,
  input  logic [iqe_pkg::ROW_W-1:0]         row_index,
  input  logic [iqe_pkg::ROW_W-1:0]         col_index,
  input  logic signed [iqe_pkg::COEF_W-1:0] coef_value,
  input  logic                              spin_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [iqe_pkg::RES_W-1:0]  result_value,
  output logic                              result_kind,
  output logic                              saturated
);
  import iqe_pkg::*;

  logic              model_kind;
  logic              ram_we, ram_re, out_busy;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [COEF_W-1:0] ram_wdata, ram_rdata;
  acc_ctrl_t         ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      model_kind <= 1'b0;
    end else if (cfg_we) begin
      model_kind <= cfg_wdata;
    end
  end

  iqe_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .model_kind (model_kind),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .row_index  (row_index),
    .col_index  (col_index),
    .coef_value (coef_value),
    .spin_value (spin_value),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .out_busy   (out_busy),
    .ctrl       (ctrl)
  );

  iqe_ram #(
    .WIDTH (COEF_W),
    .DEPTH (NUM_SPINS * NUM_SPINS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  iqe_acc u_acc (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .rdata        (ram_rdata),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .result_kind  (result_kind),
    .saturated    (saturated),
    .out_busy     (out_busy)
  );

endmodule

// ===== design/iqe_ram.sv =====
module iqe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/iqe_seq.sv =====
module iqe_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         model_kind,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   func,
  input  logic [iqe_pkg::ROW_W-1:0]    row_index,
  input  logic [iqe_pkg::ROW_W-1:0]    col_index,
  input  logic [iqe_pkg::COEF_W-1:0]   coef_value,
  input  logic                         spin_value,
  output logic                         ram_we,
  output logic [iqe_pkg::ADDR_W-1:0]   ram_waddr,
  output logic [iqe_pkg::COEF_W-1:0]   ram_wdata,
  output logic                         ram_re,
  output logic [iqe_pkg::ADDR_W-1:0]   ram_raddr,
  input  logic                         out_busy,
  output iqe_pkg::acc_ctrl_t           ctrl
);
  import iqe_pkg::*;

  state_t               state, state_next;
  logic [IDX_W-1:0]     i_idx, i_next;
  logic [IDX_W-1:0]     j_idx, j_next;
  logic [IDX_W-1:0]     wr_row, wr_row_next;
  logic [IDX_W-1:0]     wr_col, wr_col_next;
  logic [COEF_W-1:0]    wr_coef, wr_coef_next;
  logic [NUM_SPINS-1:0] spins, spins_next;
  logic                 first, first_next;
  fin_t                 fin_sel, fin_sel_next;
  logic                 kind, kind_next;
  acc_ctrl_t            ctrl_next;
  logic                 row_ok, col_ok, s_i, s_j, j_last, i_last;
  logic [IDX_W-1:0]     row_idx, col_idx;

  assign row_ok  = in_range(row_index);
  assign col_ok  = in_range(col_index);
  assign row_idx = IDX_W'(row_index);
  assign col_idx = IDX_W'(col_index);
  assign s_i     = spins[i_idx];
  assign s_j     = spins[j_idx];
  assign j_last  = (j_idx == IDX_W'(NUM_SPINS - 1));
  assign i_last  = (i_idx == IDX_W'(NUM_SPINS - 1));
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      spins <= '1;
      ctrl  <= '0;
    end else begin
      state <= state_next;
      spins <= spins_next;
      ctrl  <= ctrl_next;
    end
    i_idx   <= i_next;
    j_idx   <= j_next;
    wr_row  <= wr_row_next;
    wr_col  <= wr_col_next;
    wr_coef <= wr_coef_next;
    first   <= first_next;
    fin_sel <= fin_sel_next;
    kind    <= kind_next;
  end

  always_comb begin
    state_next   = state;
    i_next       = i_idx;
    j_next       = j_idx;
    wr_row_next  = wr_row;
    wr_col_next  = wr_col;
    wr_coef_next = wr_coef;
    spins_next   = spins;
    first_next   = first;
    fin_sel_next = fin_sel;
    kind_next    = kind;
    ctrl_next    = '0;
    ram_we       = 1'b0;
    ram_waddr    = coef_addr(wr_row, wr_col);
    ram_wdata    = wr_coef;
    ram_re       = 1'b0;
    ram_raddr    = coef_addr(i_idx, j_idx);

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (func_t'(func))
            FUNC_COEF: begin
              if (row_ok && col_ok) begin
                wr_row_next  = row_idx;
                wr_col_next  = col_idx;
                wr_coef_next = coef_value;
                state_next   = S_WR_A;
              end
            end
            FUNC_SPIN: begin
              if (row_ok) begin
                spins_next[row_idx] = spin_value;
              end
            end
            FUNC_FLIP: begin
              kind_next = KIND_FLIP;
              if (row_ok) begin
                i_next     = row_idx;
                j_next     = '0;
                first_next = 1'b1;
                state_next = S_FLIP;
              end else begin
                fin_sel_next = FIN_ZERO;
                state_next   = S_FIN;
              end
            end
            FUNC_ENERGY: begin
              kind_next  = KIND_ENERGY;
              i_next     = '0;
              j_next     = '0;
              first_next = 1'b1;
              state_next = S_ENERGY;
            end
            default: ;
          endcase
        end
      end
      S_WR_A: begin
        ram_we     = 1'b1;
        state_next = S_WR_B;
      end
      S_WR_B: begin
        ram_we     = 1'b1;
        ram_waddr  = coef_addr(wr_col, wr_row);
        state_next = S_IDLE;
      end
      S_FLIP: begin
        ram_re            = 1'b1;
        ctrl_next.term_en = 1'b1;
        ctrl_next.first   = first;
        first_next        = 1'b0;
        if (j_idx == i_idx) begin
          ctrl_next.term = TERM_ADD;
        end else if (model_kind) begin
          ctrl_next.term = s_j ? TERM_ADD : TERM_NONE;
        end else begin
          ctrl_next.term = s_j ? TERM_ADD : TERM_SUB;
        end
        if (j_last) begin
          if (model_kind) begin
            fin_sel_next = s_i ? FIN_NEG : FIN_POS;
          end else begin
            fin_sel_next = s_i ? FIN_NEG2 : FIN_POS2;
          end
          state_next = S_FIN;
        end else begin
          j_next = IDX_W'(j_idx + 1'b1);
        end
      end
      S_ENERGY: begin
        ram_re            = 1'b1;
        ctrl_next.term_en = 1'b1;
        ctrl_next.first   = first;
        first_next        = 1'b0;
        if (j_idx == i_idx) begin
          if (model_kind) begin
            ctrl_next.term = s_i ? TERM_ADD : TERM_NONE;
          end else begin
            ctrl_next.term = s_i ? TERM_ADD : TERM_SUB;
          end
        end else if (model_kind) begin
          ctrl_next.term = (s_i && s_j) ? TERM_ADD : TERM_NONE;
        end else begin
          ctrl_next.term = (s_i == s_j) ? TERM_ADD : TERM_SUB;
        end
        if (j_last && i_last) begin
          fin_sel_next = FIN_POS;
          state_next   = S_FIN;
        end else if (j_last) begin
          i_next = IDX_W'(i_idx + 1'b1);
          j_next = IDX_W'(i_idx + 1'b1);
        end else begin
          j_next = IDX_W'(j_idx + 1'b1);
        end
      end
      S_FIN: begin
        if (!out_busy) begin
          ctrl_next.fin_en = 1'b1;
          ctrl_next.fin    = fin_sel;
          ctrl_next.kind   = kind;
          state_next       = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== design/iqe_acc.sv =====
module iqe_acc (
  input  logic                              clk,
  input  logic                              rst,
  input  iqe_pkg::acc_ctrl_t                ctrl,
  input  logic [iqe_pkg::COEF_W-1:0]        rdata,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [iqe_pkg::RES_W-1:0]  result_value,
  output logic                              result_kind,
  output logic                              saturated,
  output logic                              out_busy
);
  import iqe_pkg::*;

  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(32'sh7FFF_FFFF);
  localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(32'sh8000_0000);

  logic signed [ACC_W-1:0] acc, acc_next;
  logic signed [ACC_W-1:0] coef_ext, term, base, scaled;
  logic signed [SAT_W-1:0] wide;
  logic signed [RES_W-1:0] clamp;
  logic                    clamp_sat;

  assign coef_ext = ACC_W'($signed(rdata));
  assign base     = ctrl.first ? '0 : acc;
  assign out_busy = out_valid && !out_ready;

  always_comb begin
    unique case (ctrl.term)
      TERM_ADD: term = coef_ext;
      TERM_SUB: term = -coef_ext;
      default:  term = '0;
    endcase
    acc_next = ctrl.term_en ? base + term : acc;

    unique case (ctrl.fin)
      FIN_POS:  scaled = acc;
      FIN_NEG:  scaled = -acc;
      FIN_POS2: scaled = acc <<< 1;
      FIN_NEG2: scaled = -(acc <<< 1);
      default:  scaled = '0;
    endcase
    wide = SAT_W'(scaled);
    priority if (wide > SAT_MAX) begin
      clamp     = RES_W'(SAT_MAX);
      clamp_sat = 1'b1;
    end else if (wide < SAT_MIN) begin
      clamp     = RES_W'(SAT_MIN);
      clamp_sat = 1'b1;
    end else begin
      clamp     = RES_W'(wide);
      clamp_sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.fin_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    acc <= acc_next;
    if (ctrl.fin_en) begin
      result_value <= clamp;
      result_kind  <= ctrl.kind;
      saturated    <= clamp_sat;
    end
  end

endmodule
